>>> hw/rtl/first_fit_job_shop_scheduler_assert.svh
// ---------------------------------------------------------------------------
// First-fit job-shop scheduler assertion macros
// Clocked property checks that synthesis builds drop.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_JOB_SHOP_SCHEDULER_ASSERT_SVH
`define FIRST_FIT_JOB_SHOP_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every rising clk edge outside reset.
`define FFJS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds on a rising clk edge outside reset.
`define FFJS_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FFJS_ASSERT(label, prop, msg)
`define FFJS_NEVER(label, cond, msg)
`endif
`endif

>>> hw/rtl/ffjs_pkg.sv
// ---------------------------------------------------------------------------
// ffjs_pkg
// Shared widths and defaults of the first-fit job-shop scheduler.
// ---------------------------------------------------------------------------
package ffjs_pkg;

    // Request field widths
    localparam int JOB_W  = 5;
    localparam int MACH_W = 4;
    localparam int DUR_W  = 6;
    localparam int IN_DATA_W = 16;

    // Result field widths
    localparam int TIME_W     = 12;
    localparam int OUT_DATA_W = 40;

    // Largest duration that is scheduled
    localparam int MAX_DURATION = 63;

    // Busy bitmap word: 64 time units per memory row
    localparam int WORD_W   = 64;
    localparam int WORD_LSB = 6;

    // Parameter defaults
    localparam int DEF_NUM_MACHINES = 16;
    localparam int DEF_HORIZON      = 4096;
    localparam int DEF_NUM_JOBS     = 32;

endpackage

>>> hw/rtl/first_fit_job_shop_scheduler.sv
// Flow: an out-of-range request goes straight to the result; a placed one goes through
//   T units scanned, R rows entered, D units marked and M (1-2) rows written.
// Throughput: one request at a time; the single busy-map port and the one-unit-per-cycle
//   scan, paused for each row read, set the rate, so it depends on how crowded the machine is.
// Reset: asynchronous, active low; a clearing pass zeroes the busy map one 64-unit row at a
//   time (1024 rows at defaults) before the first request.
// ---------------------------------------------------------------------------
// first_fit_job_shop_scheduler
// Greedy first-fit placement of job operations on per-machine busy bitmaps.
// ---------------------------------------------------------------------------
`include "first_fit_job_shop_scheduler_assert.svh"

module first_fit_job_shop_scheduler
    import ffjs_pkg::*;
#(
    parameter int NUM_MACHINES = DEF_NUM_MACHINES,
    parameter int HORIZON      = DEF_HORIZON,
    parameter int NUM_JOBS     = DEF_NUM_JOBS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // job[4:0], machine[8:5], duration[14:9]
    // Result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // start_time[11:0], finish_time[23:12],
                                             // makespan[35:24]
    output logic                  m_tuser    // no_fit[0]
);

    // Derived widths: machine index, job index, time unit, counter, map row
    localparam int MW     = (NUM_MACHINES > 1) ? $clog2(NUM_MACHINES) : 1;
    localparam int JW     = (NUM_JOBS > 1) ? $clog2(NUM_JOBS) : 1;
    localparam int TW_RAW = $clog2(HORIZON);
    localparam int TW     = (TW_RAW > WORD_LSB) ? TW_RAW : WORD_LSB + 1;
    localparam int CW     = TW + 1;
    localparam int ROW_W  = MW + TW - WORD_LSB;
    localparam int ROWS   = 2 ** ROW_W;
    localparam int JOBS_D = 2 ** JW;

    // Sequencer states, one-hot
    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b00_0000_0001,
        ST_IDLE   = 10'b00_0000_0010,
        ST_JSTART = 10'b00_0000_0100,
        ST_SREAD  = 10'b00_0000_1000,
        ST_SCAN   = 10'b00_0001_0000,
        ST_MREAD  = 10'b00_0010_0000,
        ST_MLOAD  = 10'b00_0100_0000,
        ST_MSET   = 10'b00_1000_0000,
        ST_MWRITE = 10'b01_0000_0000,
        ST_DONE   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Shared counter: clearing row, scan time unit, mark time unit
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [DUR_W-1:0]  run_reg, run_next;
    logic [JW-1:0]     job_reg, job_next;
    logic [MW-1:0]     mach_reg, mach_next;
    logic [DUR_W-1:0]  dur_reg, dur_next;
    logic [TW-1:0]     start_reg, start_next;
    logic [TW-1:0]     finish_reg, finish_next;
    logic              fit_reg, fit_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [TW-1:0]     span_reg, span_next;

    // Result register
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [TIME_W-1:0]     out_start_reg, out_start_next;
    logic [TIME_W-1:0]     out_finish_reg, out_finish_next;
    logic [TIME_W-1:0]     out_span_reg, out_span_next;
    logic                  out_nofit_reg, out_nofit_next;

    // Busy map: one 64-unit row per address, rows of a machine stacked
    logic [WORD_W-1:0] map_mem [ROWS];
    logic [WORD_W-1:0] map_rd_reg;
    logic              map_we;
    logic              map_re;
    logic [ROW_W-1:0]  map_addr;
    logic [WORD_W-1:0] map_wdata;

    // Job finish store, with valid bits standing in for the reset value zero
    logic [TW-1:0]     jf_mem [JOBS_D];
    logic [JOBS_D-1:0] jf_valid_reg;
    logic [TW-1:0]     jf_rd_reg;
    logic              jf_vld_rd_reg;
    logic              jf_we;

    // Request fields and range checks
    logic [JOB_W-1:0]     in_job;
    logic [MACH_W-1:0]    in_mach;
    logic [DUR_W-1:0]     in_dur;
    logic [JW+JOB_W-1:0]  in_job_ext;
    logic [MW+MACH_W-1:0] in_mach_ext;
    logic                 in_ok;
    logic                 s_accept;

    // Scan and mark helpers
    logic              cur_bit;
    logic [DUR_W-1:0]  run_inc;
    logic [CW-1:0]     cnt_inc;
    logic [CW-1:0]     rel_time;
    logic [TW-1:0]     start_calc;
    logic              at_finish;
    logic              row_end;
    logic              out_free;

    assign in_job      = s_tdata[JOB_W-1:0];
    assign in_mach     = s_tdata[JOB_W+MACH_W-1:JOB_W];
    assign in_dur      = s_tdata[JOB_W+MACH_W+DUR_W-1:JOB_W+MACH_W];
    assign in_job_ext  = (JW+JOB_W)'(in_job);
    assign in_mach_ext = (MW+MACH_W)'(in_mach);
    // Reject unknown job or machine, and a zero or oversized duration
    assign in_ok = (in_job_ext < (JW+JOB_W)'(NUM_JOBS))
                && (in_mach_ext < (MW+MACH_W)'(NUM_MACHINES))
                && (in_dur != '0)
                && ((DUR_W+1)'(in_dur) <= (DUR_W+1)'(MAX_DURATION));

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign cur_bit    = map_rd_reg[cnt_reg[WORD_LSB-1:0]];
    assign run_inc    = run_reg + DUR_W'(1);
    assign cnt_inc    = cnt_reg + CW'(1);
    assign rel_time   = (jf_vld_rd_reg ? CW'(jf_rd_reg) : CW'(0)) + CW'(1);
    assign start_calc = cnt_reg[TW-1:0] - TW'(dur_reg) + TW'(1);
    assign at_finish  = (cnt_reg[TW-1:0] == finish_reg);
    assign row_end    = &cnt_reg[WORD_LSB-1:0];
    assign out_free   = !m_tvalid_reg || m_tready;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        run_next        = run_reg;
        job_next        = job_reg;
        mach_next       = mach_reg;
        dur_next        = dur_reg;
        start_next      = start_reg;
        finish_next     = finish_reg;
        fit_next        = fit_reg;
        word_next       = word_reg;
        span_next       = span_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_start_next  = out_start_reg;
        out_finish_next = out_finish_reg;
        out_span_next   = out_span_reg;
        out_nofit_next  = out_nofit_reg;
        map_we          = 1'b0;
        map_re          = 1'b0;
        map_addr        = {mach_reg, cnt_reg[TW-1:WORD_LSB]};
        map_wdata       = word_reg;
        jf_we           = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Zero one row per cycle
                map_we    = 1'b1;
                map_addr  = cnt_reg[ROW_W-1:0];
                map_wdata = '0;
                if (&cnt_reg[ROW_W-1:0])
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    job_next   = in_job_ext[JW-1:0];
                    mach_next  = in_mach_ext[MW-1:0];
                    dur_next   = in_dur;
                    run_next   = '0;
                    fit_next   = 1'b0;
                    state_next = in_ok ? ST_JSTART : ST_DONE;
                end
            end
            ST_JSTART:
            begin
                // Start one unit after the job's last finish
                cnt_next   = rel_time;
                state_next = (rel_time >= CW'(HORIZON)) ? ST_DONE : ST_SREAD;
            end
            ST_SREAD:
            begin
                map_re     = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (!cur_bit && (run_inc == dur_reg))
                begin
                    // Window found: rewind the counter to its first unit
                    fit_next    = 1'b1;
                    finish_next = cnt_reg[TW-1:0];
                    start_next  = start_calc;
                    cnt_next    = CW'(start_calc);
                    state_next  = ST_MREAD;
                end
                else
                begin
                    run_next = cur_bit ? '0 : run_inc;
                    cnt_next = cnt_inc;
                    priority if (cnt_inc >= CW'(HORIZON))
                        state_next = ST_DONE;
                    else if (row_end)
                        state_next = ST_SREAD;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_MREAD:
            begin
                map_re     = 1'b1;
                state_next = ST_MLOAD;
            end
            ST_MLOAD:
            begin
                word_next  = map_rd_reg;
                state_next = ST_MSET;
            end
            ST_MSET:
            begin
                word_next[cnt_reg[WORD_LSB-1:0]] = 1'b1;
                if (at_finish || row_end)
                    state_next = ST_MWRITE;
                else
                    cnt_next = cnt_inc;
            end
            ST_MWRITE:
            begin
                map_we = 1'b1;
                if (at_finish)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next   = cnt_inc;
                    state_next = ST_MREAD;
                end
            end
            ST_DONE:
            begin
                // Hold until the result register is free
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    out_nofit_next = !fit_reg;
                    if (fit_reg)
                    begin
                        jf_we           = 1'b1;
                        out_start_next  = TIME_W'(start_reg);
                        out_finish_next = TIME_W'(finish_reg);
                        if (finish_reg > span_reg)
                        begin
                            span_next     = finish_reg;
                            out_span_next = TIME_W'(finish_reg);
                        end
                        else
                        begin
                            out_span_next = TIME_W'(span_reg);
                        end
                    end
                    else
                    begin
                        out_start_next  = '0;
                        out_finish_next = '0;
                        out_span_next   = TIME_W'(span_reg);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            span_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            jf_valid_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            span_reg     <= span_next;
            m_tvalid_reg <= m_tvalid_next;
            if (jf_we)
                jf_valid_reg[job_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg        <= run_next;
        job_reg        <= job_next;
        mach_reg       <= mach_next;
        dur_reg        <= dur_next;
        start_reg      <= start_next;
        finish_reg     <= finish_next;
        fit_reg        <= fit_next;
        word_reg       <= word_next;
        out_start_reg  <= out_start_next;
        out_finish_reg <= out_finish_next;
        out_span_reg   <= out_span_next;
        out_nofit_reg  <= out_nofit_next;
    end

    // Busy map port
    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_addr] <= map_wdata;
        if (map_re)
            map_rd_reg <= map_mem[map_addr];
    end

    // Job finish store: read on request accept, write on placement
    always_ff @(posedge clk)
    begin
        if (jf_we)
            jf_mem[job_reg] <= finish_reg;
        if (s_accept)
        begin
            jf_rd_reg     <= jf_mem[in_job_ext[JW-1:0]];
            jf_vld_rd_reg <= jf_valid_reg[in_job_ext[JW-1:0]];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_DATA_W - 3*TIME_W)'(0), out_span_reg, out_finish_reg,
                       out_start_reg};
    assign m_tuser  = out_nofit_reg;

    `FFJS_ASSERT(a_scan_in_horizon, (state_reg == ST_SCAN) |-> (cnt_reg < CW'(HORIZON)),
        "scan past horizon")
    `FFJS_ASSERT(a_run_below_dur, (state_reg == ST_SCAN) |-> (run_reg < dur_reg),
        "free run reached duration without placement")
    `FFJS_ASSERT(a_mark_in_window,
        (state_reg == ST_MSET) |-> ((cnt_reg[TW-1:0] <= finish_reg)
                                 && (cnt_reg[TW-1:0] >= start_reg)),
        "marking outside the placed window")
    `FFJS_NEVER(a_span_covers_finish,
        m_tvalid_reg && !out_nofit_reg && (out_span_reg < out_finish_reg),
        "makespan below finish time")

endmodule
